// File: rtl/core/pltw_pkg.sv
`default_nettype none
package pltw_pkg;

   localparam int unsigned ADDR_W    = 64;
   localparam int unsigned VA_W      = 48;
   localparam int unsigned IDX_W     = 9;
   localparam int unsigned OFF_W     = 12;
   localparam int unsigned LEVEL_W   = 3;
   localparam int unsigned CSR_IDX_W = 4;

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECT_MAP_BASE  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_MAP_START = 4'd1;

   // register reset values
   localparam logic [ADDR_W-1:0] RESET_DIRECT_MAP_BASE  = 64'hffff_8880_0000_0000;
   localparam logic [ADDR_W-1:0] RESET_KERNEL_MAP_START = 64'hffff_ffff_8000_0000;

   // frame bits 12..51 of a table entry
   localparam logic [ADDR_W-1:0] FRAME_MASK = 64'h000f_ffff_ffff_f000;

   // walk levels
   localparam logic [1:0]         LEVEL_BOTTOM = 2'd3;
   localparam logic [LEVEL_W-1:0] LEVEL_FINAL  = 3'd4;

   // request function codes
   localparam logic FUNC_TRANSLATE = 1'b0;
   localparam logic FUNC_READ_RSP  = 1'b1;

   typedef enum logic [1:0] {
      KIND_READ = 2'd0,
      KIND_DONE = 2'd1,
      KIND_FAIL = 2'd2
   } kind_type;

   // one result in flight between front and back; address is base + low
   typedef struct packed {
      kind_type             kind;
      logic [ADDR_W-1:0]    base;
      logic [OFF_W-1:0]     low;
      logic [LEVEL_W-1:0]   level;
   } pltw_op_type;

   // 9-bit table index of a virtual address for table level lv
   function automatic logic [IDX_W-1:0] table_index(logic [VA_W-1:0] va, logic [1:0] lv);
      logic [IDX_W-1:0] idx;
      case (lv)
         2'd0:    idx = va[47:39];
         2'd1:    idx = va[38:30];
         2'd2:    idx = va[29:21];
         default: idx = va[20:12];
      endcase
      return idx;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/pltw_req_if.sv
`default_nettype none
interface pltw_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [63:0] virt_addr;
   logic [63:0] root_pointer;
   logic [63:0] read_data;
   logic        read_ok;

   modport source (output valid, func, virt_addr, root_pointer, read_data, read_ok,
                   input ready);
   modport sink   (input valid, func, virt_addr, root_pointer, read_data, read_ok,
                   output ready);
endinterface
`default_nettype wire

// File: rtl/core/pltw_rsp_if.sv
`default_nettype none
interface pltw_rsp_if;
   import pltw_pkg::*;
   logic        valid;
   logic        ready;
   kind_type    kind;
   logic [63:0] address;
   logic [2:0]  level;

   modport source (output valid, kind, address, level, input ready);
   modport sink   (input valid, kind, address, level, output ready);
endinterface
`default_nettype wire

// File: rtl/core/pltw_csr_if.sv
`default_nettype none
interface pltw_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [63:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/pltw_front.sv
`default_nettype none
module pltw_front (
   input  wire                  clock,
   input  wire                  reset,
   pltw_req_if.sink             req_bus,
   pltw_csr_if.sink             csr_bus,
   input  wire                  push_ready,
   output logic                 push_valid,
   output pltw_pkg::pltw_op_type push_op
);
   import pltw_pkg::*;

   logic [ADDR_W-1:0] dmb_ff, dmb_in;
   logic [ADDR_W-1:0] kms_ff, kms_in;
   logic              active_ff, active_in;
   logic [1:0]        level_ff, level_in;
   logic [VA_W-1:0]   va_ff, va_in;

   logic              accept;
   logic              has_result;
   logic [1:0]        next_level;
   logic [ADDR_W-1:0] phys_root;
   logic [ADDR_W-1:0] frame;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = push_ready;
   assign accept        = req_bus.valid && push_ready;
   assign push_valid    = accept && has_result;

   // root conversion and entry frame
   assign phys_root  = (req_bus.root_pointer >= kms_ff) ? '0 : req_bus.root_pointer - dmb_ff;
   assign frame      = req_bus.read_data & FRAME_MASK;
   assign next_level = level_ff + 2'd1;

   // classify the request and form the pending result
   always_comb begin
      dmb_in     = dmb_ff;
      kms_in     = kms_ff;
      active_in  = active_ff;
      level_in   = level_ff;
      va_in      = va_ff;
      has_result = 1'b0;
      push_op    = '{kind: KIND_FAIL, base: '0, low: '0, level: '0};

      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_DIRECT_MAP_BASE:  dmb_in = csr_bus.data;
            CSR_KERNEL_MAP_START: kms_in = csr_bus.data;
            default: ;
         endcase
      end

      if (req_bus.func == FUNC_TRANSLATE) begin
         has_result    = 1'b1;
         push_op.kind  = KIND_READ;
         push_op.base  = phys_root;
         push_op.low   = {table_index(req_bus.virt_addr[VA_W-1:0], 2'd0), 3'b000};
         push_op.level = '0;
         if (accept) begin
            active_in = 1'b1;
            level_in  = '0;
            va_in     = req_bus.virt_addr[VA_W-1:0];
         end
      end else if (active_ff) begin
         has_result = 1'b1;
         if (!req_bus.read_ok) begin
            // failed read ends the walk
            push_op.kind  = KIND_FAIL;
            push_op.level = {1'b0, level_ff};
            if (accept) begin
               active_in = 1'b0;
            end
         end else if (level_ff != LEVEL_BOTTOM) begin
            push_op.kind  = KIND_READ;
            push_op.base  = frame;
            push_op.low   = {table_index(va_ff, next_level), 3'b000};
            push_op.level = {1'b0, next_level};
            if (accept) begin
               level_in = next_level;
            end
         end else begin
            // frame low bits are zero, so the add merges the page offset
            push_op.kind  = KIND_DONE;
            push_op.base  = frame;
            push_op.low   = va_ff[OFF_W-1:0];
            push_op.level = LEVEL_FINAL;
            if (accept) begin
               active_in = 1'b0;
               level_in  = '0;
            end
         end
      end
   end

   // walk state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dmb_ff    <= RESET_DIRECT_MAP_BASE;
         kms_ff    <= RESET_KERNEL_MAP_START;
         active_ff <= 1'b0;
         level_ff  <= '0;
         va_ff     <= '0;
      end else begin
         dmb_ff    <= dmb_in;
         kms_ff    <= kms_in;
         active_ff <= active_in;
         level_ff  <= level_in;
         va_ff     <= va_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/pltw_queue.sv
`default_nettype none
module pltw_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push_valid,
   input  pltw_pkg::pltw_op_type push_op,
   output logic                  push_ready,
   output logic                  pop_valid,
   output pltw_pkg::pltw_op_type pop_op,
   input  wire                   pop_ready
);
   import pltw_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   pltw_op_type        slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_op     = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/pltw_back.sv
`default_nettype none
module pltw_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   pop_valid,
   input  pltw_pkg::pltw_op_type pop_op,
   output logic                  pop_ready,
   pltw_rsp_if.source            rsp_bus
);
   import pltw_pkg::*;

   logic              valid_ff, valid_in;
   kind_type          kind_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic              load;

   assign pop_ready = !valid_ff || rsp_bus.ready;
   assign load      = pop_valid && pop_ready;
   assign valid_in  = load || (valid_ff && !rsp_bus.ready);

   // output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // final address add and output register
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= pop_op.kind;
         addr_ff  <= pop_op.base + {{(ADDR_W - OFF_W){1'b0}}, pop_op.low};
         level_ff <= pop_op.level;
      end
   end

   assign rsp_bus.valid   = valid_ff;
   assign rsp_bus.kind    = kind_ff;
   assign rsp_bus.address = addr_ff;
   assign rsp_bus.level   = level_ff;

endmodule
`default_nettype wire

// File: rtl/core/four_level_page_table_walker.sv
`default_nettype none
// an accepted request is written into a queue slot and later loaded into the output
// register that drives the response; a stalled response holds back both
// throughput: one request per cycle while the queue has room; each response costs only
// a mask and one add; the walk rate is set by the memory round trip outside the block
// reset clears the walk state, empties the queue and output register, and
// restores both csr registers to their default values
module four_level_page_table_walker #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire        clock,
   input  wire        reset,
   pltw_req_if.sink   req_bus,
   pltw_rsp_if.source rsp_bus,
   pltw_csr_if.sink   csr_bus
);
   import pltw_pkg::*;

   logic        push_valid;
   logic        push_ready;
   pltw_op_type push_op;
   logic        pop_valid;
   logic        pop_ready;
   pltw_op_type pop_op;

   // classify requests and track the walk
   pltw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_op    (push_op)
   );

   // decoupling queue
   pltw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_op     (pop_op),
      .pop_ready  (pop_ready)
   );

   // address generation and response register
   pltw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_op    (pop_op),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule
`default_nettype wire
